// ===== hdl/eps_pkg.sv =====
package eps_pkg;

    // Largest subset sum tracked in the bitset.
    localparam int HALF_MAX = 1023;

    // Payload widths
    localparam int VALUE_W = 10;
    localparam int TOTAL_W = 12;
    localparam logic [TOTAL_W-1:0] TOTAL_CAP = '1;

    // Bitset geometry: 64-bit words
    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;
    localparam int NWORDS   = (HALF_MAX + WORD_W) / WORD_W;
    localparam int IDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int WS_W     = VALUE_W - BIT_W;
    localparam int CNT_W    = $clog2(NWORDS + 2);
    localparam int PTR_W    = ((CNT_W > WS_W) ? CNT_W : WS_W) + 2;
    localparam int TOP_BITS = HALF_MAX % WORD_W;
    localparam int TWICE_HALF = 2 * HALF_MAX;

    localparam logic [WORD_W-1:0] TOP_MASK = (TOP_BITS == WORD_W - 1) ? '1 :
        ((WORD_W'(1) << (TOP_BITS + 1)) - WORD_W'(1));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_REPORT
    } eps_state_t;

    typedef struct packed {
        logic load;
        logic upd;
        logic check;
        logic report;
    } eps_cmd_t;

    typedef struct packed {
        logic needs_upd;
        logic upd_done;
    } eps_stat_t;

endpackage

// ===== hdl/eps_ctrl.sv =====
module eps_ctrl
    import eps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      last,
    input  eps_stat_t stat,
    output eps_cmd_t  cmd,
    output logic      busy
);

    eps_state_t state_reg;
    eps_state_t state_next;
    logic       last_reg;
    logic       last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last;
                    if (stat.needs_upd)
                        state_next = ST_UPDATE;
                    else if (last)
                        state_next = ST_CHECK;
                end
            end
            ST_UPDATE:
            begin
                if (stat.upd_done)
                    state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
                state_next = ST_REPORT;
            ST_REPORT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_UPDATE:
                cmd.upd = 1'b1;
            ST_CHECK:
                cmd.check = 1'b1;
            ST_REPORT:
                cmd.report = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

// ===== hdl/eps_dpath.sv =====
module eps_dpath
    import eps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  eps_cmd_t           cmd,
    output eps_stat_t          stat,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic               can_split,
    output logic               sum_overflow,
    output logic [TOTAL_W-1:0] total_sum
);

    logic [WORD_W-1:0]  mem [NWORDS];
    logic [NWORDS-1:0]  valid_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               sat_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [WORD_W-1:0]  a_mem_reg;
    logic               a_range_reg;
    logic               a_valid_reg;
    logic               a_zero_reg;
    logic [WORD_W-1:0]  prev_a_reg;
    logic [WORD_W-1:0]  b_mem_reg;
    logic               b_valid_reg;
    logic               b_zero_reg;

    logic               done_reg;
    logic               split_reg;
    logic               ovf_reg;
    logic [TOTAL_W-1:0] total_out_reg;

    logic [TOTAL_W:0]   sum_wide;
    logic [BIT_W-1:0]   bs;
    logic [WS_W-1:0]    ws;
    logic [PTR_W-1:0]   ra;
    logic [PTR_W-1:0]   rb;
    logic [PTR_W-1:0]   wr;
    logic [IDX_W-1:0]   ra_idx;
    logic [IDX_W-1:0]   rb_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   h_idx;
    logic [TOTAL_W-2:0] half;
    logic [WORD_W-1:0]  rd_a_word;
    logic [WORD_W-1:0]  rd_b_word;
    logic [WORD_W-1:0]  shifted;
    logic [WORD_W-1:0]  new_word;
    logic               wr_en;
    logic               ovf;
    logic               split;

    assign bs = value_reg[BIT_W-1:0];
    assign ws = value_reg[VALUE_W-1:BIT_W];

    // Source word counts down from the top minus the word shift
    assign ra     = PTR_W'(NWORDS - 1) - PTR_W'(ws) - PTR_W'(cnt_reg);
    assign rb     = PTR_W'(NWORDS) - PTR_W'(cnt_reg);
    assign wr     = PTR_W'(NWORDS + 1) - PTR_W'(cnt_reg);
    assign ra_idx = ra[IDX_W-1:0];
    assign wr_idx = wr[IDX_W-1:0];
    assign half   = total_reg[TOTAL_W-1:1];
    assign h_idx  = IDX_W'(half >> BIT_W);
    assign rb_idx = cmd.check ? h_idx : rb[IDX_W-1:0];

    // An unwritten word reads as the cleared bitset
    always_comb
    begin
        if (!a_range_reg)
            rd_a_word = '0;
        else if (a_valid_reg)
            rd_a_word = a_mem_reg;
        else
            rd_a_word = WORD_W'(a_zero_reg);

        if (b_valid_reg)
            rd_b_word = b_mem_reg;
        else
            rd_b_word = WORD_W'(b_zero_reg);
    end

    // Funnel shift across the word boundary; a zero bit shift drops the low word
    assign shifted  = (prev_a_reg << bs) | ((rd_a_word >> 1) >> (~bs));
    assign new_word = (wr_idx == IDX_W'(NWORDS - 1)) ? ((rd_b_word | shifted) & TOP_MASK)
                                                     : (rd_b_word | shifted);
    assign wr_en    = cmd.upd && (cnt_reg >= CNT_W'(2));

    assign sum_wide = {1'b0, total_reg} + (TOTAL_W + 1)'(value);
    assign ovf      = sat_reg || (32'(total_reg) > TWICE_HALF);
    assign split    = !ovf && !total_reg[0] && rd_b_word[half[BIT_W-1:0]];

    assign stat.needs_upd = (value != '0) && (32'(value) <= HALF_MAX);
    assign stat.upd_done  = (cnt_reg == CNT_W'(NWORDS + 1));

    // Bitset storage and registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= new_word;
        a_mem_reg   <= mem[ra_idx];
        a_range_reg <= !ra[PTR_W-1];
        a_valid_reg <= valid_reg[ra_idx];
        a_zero_reg  <= (ra_idx == '0);
        prev_a_reg  <= rd_a_word;
        b_mem_reg   <= mem[rb_idx];
        b_valid_reg <= valid_reg[rb_idx];
        b_zero_reg  <= (rb_idx == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            value_reg <= value;
        if (cmd.report)
        begin
            split_reg     <= split;
            ovf_reg       <= ovf;
            total_out_reg <= total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            sat_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
            if (cmd.load)
            begin
                cnt_reg <= '0;
                if (sum_wide > (TOTAL_W + 1)'(TOTAL_CAP))
                begin
                    total_reg <= TOTAL_CAP;
                    sat_reg   <= 1'b1;
                end
                else
                    total_reg <= sum_wide[TOTAL_W-1:0];
            end
            else if (cmd.upd)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            if (cmd.report)
            begin
                valid_reg <= '0;
                total_reg <= '0;
                sat_reg   <= 1'b0;
            end
        end
    end

    assign done         = done_reg;
    assign can_split    = split_reg;
    assign sum_overflow = ovf_reg;
    assign total_sum    = total_out_reg;

endmodule

// ===== hdl/equal_partition_subset_sum.sv =====
// Equal-partition subset-sum engine.
// Feed the elements of a set one request at a time: drive value and last with
// start high; the request is taken at a clock edge where busy is low. last
// marks the final element of the set.
// Each element with a value from 1 to HALF_MAX ORs a shifted copy of the
// reachable-sum bitset into itself, walking the NWORDS 64-bit words from the
// top down through a two-read-port word memory; busy stays high through the
// update, so no further request is taken until it ends. Zero or out-of-range
// values only add to the total and, unless last, leave the block free.
// After the last element, the CHECK and REPORT states read the word holding
// total/2; done then pulses for one cycle with can_split, sum_overflow and
// total_sum.
// Results stay on the outputs until the next result; done marks them for
// exactly one cycle and the receiver cannot stall the block. A new request
// may start in that cycle. Reset, and every result, clear the total and the
// bitset to the set {0}; per-word valid flags do the clearing with no sweep.
module equal_partition_subset_sum
    import eps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               done,
    output logic               can_split,
    output logic               sum_overflow,
    output logic [TOTAL_W-1:0] total_sum
);

    eps_cmd_t  cmd;
    eps_stat_t stat;

    // Sequence each request: accept, bitset sweep, half-sum lookup, report
    eps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the bitset memory, running total and result registers
    eps_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .value        (value),
        .done         (done),
        .can_split    (can_split),
        .sum_overflow (sum_overflow),
        .total_sum    (total_sum)
    );

    // A result only appears once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An oversized total never reports a split
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && sum_overflow) |-> !can_split)
        else $error("split reported with overflow");

    // A split needs an even total
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && can_split) |-> !total_sum[0])
        else $error("split reported with odd total");

    // No result directly after an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too soon after request");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import eps_pkg::*;

    // Cycles with no request taken and no verdict seen before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;
    // Drain time after the last verdict, a little over one full update.
    localparam int TAIL_CYCLES = NWORDS + 8;
    localparam int ITEM_GOAL = 1750;
    localparam int BALANCED_GOAL = 1050;

    typedef struct packed {
        logic               can_split;
        logic               sum_overflow;
        logic [TOTAL_W-1:0] total_sum;
    } verdict_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               done;
    logic               can_split;
    logic               sum_overflow;
    logic [TOTAL_W-1:0] total_sum;

    // Shadow of the block: reachable sums, clipped running total, sticky clip flag.
    logic [HALF_MAX:0]  reach_set;
    int                 set_total;
    logic               set_clipped;

    verdict_t           expected_verdicts[$];
    logic [VALUE_W-1:0] staged_set[$];
    int                 items_sent;
    int                 fail_count;
    int                 idle_cycles;
    // When set, requests go out back to back with no hold-off.
    logic               quiet_mode;

    equal_partition_subset_sum DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .done         (done),
        .can_split    (can_split),
        .sum_overflow (sum_overflow),
        .total_sum    (total_sum)
    );

    always #10 clk = ~clk;

    // Clear the shadow back to the set {0} with a zero total.
    function automatic void clear_partition_state();
        reach_set = '0;
        reach_set[0] = 1'b1;
        set_total = 0;
        set_clipped = 1'b0;
    endfunction

    // Fold one accepted element into the shadow; on the last element, queue the verdict.
    function automatic void fold_element(input logic [VALUE_W-1:0] elem, input logic is_last);
        verdict_t verdict;
        int       half;
        set_total = set_total + int'(elem);
        if (set_total > int'(TOTAL_CAP))
        begin
            set_total = int'(TOTAL_CAP);
            set_clipped = 1'b1;
        end
        // Shift-OR of the old set; sums beyond HALF_MAX fall off the top.
        if (elem != 0 && int'(elem) <= HALF_MAX)
            reach_set = reach_set | (reach_set << elem);
        if (!is_last)
            return;
        verdict.sum_overflow = set_clipped || (set_total > TWICE_HALF);
        verdict.can_split = 1'b0;
        if (!verdict.sum_overflow && set_total[0] == 1'b0)
        begin
            half = set_total / 2;
            verdict.can_split = reach_set[half];
        end
        verdict.total_sum = TOTAL_W'(set_total);
        expected_verdicts.push_back(verdict);
        clear_partition_state();
    endfunction

    function automatic int draw_gap();
        if (quiet_mode)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    // Pick a magnitude so that small, medium and full-range values all show up.
    function automatic int value_scale();
        case ($urandom_range(0, 3))
            0: return 15;
            1: return 63;
            2: return 255;
            default: return 1023;
        endcase
    endfunction

    // Hold off for a random gap, then present one request until the block takes it.
    task automatic send_request(input logic [VALUE_W-1:0] elem, input logic is_last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= elem;
        last  <= is_last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fold_element(elem, is_last);
        items_sent++;
    endtask

    // Send the staged set in order, marking the final element, then redraw the idling mode.
    task automatic send_set();
        int j;
        for (j = 0; j < staged_set.size(); j++)
            send_request(staged_set[j], j == staged_set.size() - 1);
        staged_set.delete();
        quiet_mode = ($urandom_range(0, 3) == 0);
    endtask

    // Single-element sets: a lone zero splits, a lone odd value does not.
    task automatic test_single_element_sets();
        staged_set = '{VALUE_W'(0)};
        send_set();
        staged_set = '{VALUE_W'(1023)};
        send_set();
    endtask

    // Zero elements, reachable and unreachable halves, odd totals.
    task automatic test_split_decisions();
        staged_set = '{VALUE_W'(0), VALUE_W'(0), VALUE_W'(5), VALUE_W'(5)};
        send_set();
        staged_set = '{VALUE_W'(1), VALUE_W'(2), VALUE_W'(3)};
        send_set();
        staged_set = '{VALUE_W'(1), VALUE_W'(2), VALUE_W'(4)};
        send_set();
        // Even total whose half is not a subset sum.
        staged_set = '{VALUE_W'(2), VALUE_W'(4), VALUE_W'(8)};
        send_set();
    endtask

    // Largest total that still fits, one past it, and a total that clips at the cap.
    task automatic test_overflow_limits();
        staged_set = '{VALUE_W'(1023), VALUE_W'(1023)};
        send_set();
        staged_set = '{VALUE_W'(1023), VALUE_W'(1023), VALUE_W'(1)};
        send_set();
        repeat (5) staged_set.push_back(VALUE_W'(1023));
        send_set();
    endtask

    // Mostly sets built from two halves of equal sum, shuffled; some get a stray
    // extra element so they no longer balance.
    task automatic test_balanced_sets(input int item_goal);
        int cap;
        int part;
        int half_sum;
        int remaining;
        int j;
        int pick;
        logic [VALUE_W-1:0] swap_val;
        while (items_sent < item_goal)
        begin
            cap = value_scale();
            half_sum = 0;
            repeat ($urandom_range(1, 4))
            begin
                part = $urandom_range(0, cap);
                if (half_sum + part > HALF_MAX)
                    part = HALF_MAX - half_sum;
                staged_set.push_back(VALUE_W'(part));
                half_sum += part;
            end
            // Build the other side from random pieces of the same sum.
            remaining = half_sum;
            while (remaining > 0)
            begin
                part = $urandom_range(1, (remaining < cap) ? remaining : cap);
                staged_set.push_back(VALUE_W'(part));
                remaining -= part;
            end
            if ($urandom_range(0, 3) == 0)
                staged_set.push_back(VALUE_W'(0));
            if ($urandom_range(0, 4) == 0)
                staged_set.push_back(VALUE_W'($urandom_range(1, value_scale())));
            for (j = staged_set.size() - 1; j > 0; j--)
            begin
                pick = $urandom_range(0, j);
                swap_val = staged_set[j];
                staged_set[j] = staged_set[pick];
                staged_set[pick] = swap_val;
            end
            send_set();
        end
    endtask

    // Free-form sets: short random ones, long ones that run past the cap,
    // and runs of the largest value.
    task automatic test_random_sets(input int item_goal);
        int set_len;
        int cap;
        while (items_sent < item_goal)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    set_len = $urandom_range(1, 6);
                    repeat (set_len) staged_set.push_back(VALUE_W'(1023));
                end
                1:
                begin
                    set_len = $urandom_range(5, 24);
                    repeat (set_len) staged_set.push_back(VALUE_W'($urandom_range(0, 1023)));
                end
                default:
                begin
                    set_len = $urandom_range(1, 8);
                    cap = value_scale();
                    repeat (set_len) staged_set.push_back(VALUE_W'($urandom_range(0, cap)));
                end
            endcase
            send_set();
        end
    endtask

    // Compare every verdict against the oldest one predicted.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict with none expected: can_split %0d sum_overflow %0d total_sum %0d",
                       can_split, sum_overflow, total_sum);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (can_split !== want.can_split)
                begin
                    $error("can_split: expected %0d, got %0d", want.can_split, can_split);
                    fail_count++;
                end
                if (sum_overflow !== want.sum_overflow)
                begin
                    $error("sum_overflow: expected %0d, got %0d", want.sum_overflow, sum_overflow);
                    fail_count++;
                end
                if (total_sum !== want.total_sum)
                begin
                    $error("total_sum: expected %0d, got %0d", want.total_sum, total_sum);
                    fail_count++;
                end
            end
        end
    end

    // Hang detection: count cycles in which neither a request nor a verdict moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        last = 1'b0;
        items_sent = 0;
        fail_count = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        clear_partition_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element_sets();
        test_split_decisions();
        test_overflow_limits();
        test_balanced_sets(BALANCED_GOAL);
        test_random_sets(ITEM_GOAL);

        // Drop start once the last request is taken, then drain outstanding verdicts.
        start <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
